FILE: hw/rtl/sta_pkg.sv
package sta_pkg;

	// coordinate width and cordic step count
	localparam int COORD_BITS   = 16;
	localparam int CORDIC_STEPS = 16;

	// derived datapath widths
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int SUM_W  = PROD_W + 1;
	// headroom for the cordic gain and the pre-rotation swap
	localparam int CW     = SUM_W + 3;
	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	// angle format, radians times 8192
	localparam int ANG_W = 16;
	localparam logic signed [ANG_W-1:0] ANG_ZERO    = '0;
	localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 16'sd12868;
	localparam logic signed [ANG_W-1:0] ANG_PI      = 16'sd25736;

	// vector being rotated, plus the cross-is-zero shortcut
	typedef struct packed {
		logic                    bypass;
		logic                    bypass_pi;
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ANG_W-1:0] z;
	} rot_t;

	// round(atan(2^-i) * 8192)
	function automatic logic signed [ANG_W-1:0] atan_entry(input int unsigned i);
		logic signed [ANG_W-1:0] e;
		case (i)
			0:       e = 16'sd6434;
			1:       e = 16'sd3798;
			2:       e = 16'sd2007;
			3:       e = 16'sd1019;
			4:       e = 16'sd511;
			5:       e = 16'sd256;
			6:       e = 16'sd128;
			7:       e = 16'sd64;
			8:       e = 16'sd32;
			9:       e = 16'sd16;
			10:      e = 16'sd8;
			11:      e = 16'sd4;
			12:      e = 16'sd2;
			13:      e = 16'sd1;
			default: e = '0;
		endcase
		return e;
	endfunction

endpackage

FILE: hw/rtl/sta_front.sv
module sta_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_vld,
	input  logic signed [sta_pkg::COORD_BITS-1:0] a_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] a_x,
	input  logic signed [sta_pkg::COORD_BITS-1:0] b_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] b_x,
	input  logic signed [sta_pkg::COORD_BITS-1:0] c_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] c_x,
	output logic                                  out_vld,
	output sta_pkg::rot_t                         out_rot
);

	// stage 1: segment vectors
	logic                              vld_s1;
	logic signed [sta_pkg::DIFF_W-1:0] ab_y_s1, ab_x_s1, bc_y_s1, bc_x_s1;
	// stage 2: partial products
	logic                              vld_s2;
	logic signed [sta_pkg::PROD_W-1:0] yy_s2, xx_s2, xy_s2, yx_s2;
	// stage 3: dot and cross
	logic                              vld_s3;
	logic signed [sta_pkg::SUM_W-1:0]  dot_s3, cross_s3;
	// stage 4: quadrant pre-rotation
	logic                              vld_s4;
	sta_pkg::rot_t                     rot_s4;

	logic signed [sta_pkg::CW-1:0]     dot_ext, cross_ext;
	sta_pkg::rot_t                     rot_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_comb begin
		dot_ext           = sta_pkg::CW'(dot_s3);
		cross_ext         = sta_pkg::CW'(cross_s3);
		rot_nxt.bypass    = (cross_s3 == '0);
		rot_nxt.bypass_pi = dot_s3[sta_pkg::SUM_W-1];
		rot_nxt.x         = dot_ext;
		rot_nxt.y         = cross_ext;
		rot_nxt.z         = sta_pkg::ANG_ZERO;
		if (dot_s3[sta_pkg::SUM_W-1]) begin
			if (cross_s3 > 0) begin
				rot_nxt.x = cross_ext;
				rot_nxt.y = -dot_ext;
				rot_nxt.z = sta_pkg::ANG_HALF_PI;
			end else begin
				rot_nxt.x = -cross_ext;
				rot_nxt.y = dot_ext;
				rot_nxt.z = -sta_pkg::ANG_HALF_PI;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ab_y_s1  <= sta_pkg::DIFF_W'(b_y) - sta_pkg::DIFF_W'(a_y);
			ab_x_s1  <= sta_pkg::DIFF_W'(b_x) - sta_pkg::DIFF_W'(a_x);
			bc_y_s1  <= sta_pkg::DIFF_W'(c_y) - sta_pkg::DIFF_W'(b_y);
			bc_x_s1  <= sta_pkg::DIFF_W'(c_x) - sta_pkg::DIFF_W'(b_x);
			yy_s2    <= sta_pkg::PROD_W'(ab_y_s1) * sta_pkg::PROD_W'(bc_y_s1);
			xx_s2    <= sta_pkg::PROD_W'(ab_x_s1) * sta_pkg::PROD_W'(bc_x_s1);
			xy_s2    <= sta_pkg::PROD_W'(ab_x_s1) * sta_pkg::PROD_W'(bc_y_s1);
			yx_s2    <= sta_pkg::PROD_W'(ab_y_s1) * sta_pkg::PROD_W'(bc_x_s1);
			dot_s3   <= sta_pkg::SUM_W'(yy_s2) + sta_pkg::SUM_W'(xx_s2);
			cross_s3 <= sta_pkg::SUM_W'(xy_s2) - sta_pkg::SUM_W'(yx_s2);
			rot_s4   <= rot_nxt;
		end
	end

	assign out_vld = vld_s4;
	assign out_rot = rot_s4;

endmodule

FILE: hw/rtl/sta_cordic_step.sv
module sta_cordic_step (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic [sta_pkg::STEP_W-1:0]     step,
	input  logic                           in_vld,
	input  sta_pkg::rot_t                  in_rot,
	output logic                           out_vld,
	output sta_pkg::rot_t                  out_rot
);

	logic                              vld_s1;
	sta_pkg::rot_t                     rot_s1;
	logic signed [sta_pkg::CW-1:0]     dx, dy;
	logic signed [sta_pkg::ANG_W-1:0]  ang;
	sta_pkg::rot_t                     rot_nxt;

	// one vectoring micro-rotation, floor shifts on the old x and y
	always_comb begin
		dx      = in_rot.y >>> step;
		dy      = in_rot.x >>> step;
		ang     = sta_pkg::atan_entry(32'(step));
		rot_nxt = in_rot;
		if (!in_rot.y[sta_pkg::CW-1]) begin
			rot_nxt.x = in_rot.x + dx;
			rot_nxt.y = in_rot.y - dy;
			rot_nxt.z = in_rot.z + ang;
		end else begin
			rot_nxt.x = in_rot.x - dx;
			rot_nxt.y = in_rot.y + dy;
			rot_nxt.z = in_rot.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1 <= rot_nxt;
		end
	end

	assign out_vld = vld_s1;
	assign out_rot = rot_s1;

endmodule

FILE: hw/rtl/sta_out.sv
module sta_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  sta_pkg::rot_t                      in_rot,
	output logic                               en,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [sta_pkg::ANG_W-1:0]   turn_angle
);

	logic                              out_valid_q;
	logic signed [sta_pkg::ANG_W-1:0]  out_ang_q;
	logic                              skid_valid_q;
	logic signed [sta_pkg::ANG_W-1:0]  skid_ang_q;
	logic signed [sta_pkg::ANG_W-1:0]  res;
	logic                              arrive;

	// shortcut for zero cross, else clamp to +-pi
	always_comb begin
		if (in_rot.bypass) begin
			res = in_rot.bypass_pi ? sta_pkg::ANG_PI : sta_pkg::ANG_ZERO;
		end else if (in_rot.z > sta_pkg::ANG_PI) begin
			res = sta_pkg::ANG_PI;
		end else if (in_rot.z < -sta_pkg::ANG_PI) begin
			res = -sta_pkg::ANG_PI;
		end else begin
			res = in_rot.z;
		end
	end

	assign en     = !skid_valid_q;
	assign arrive = in_vld && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (!out_valid_q || !out_stall) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (arrive) begin
			if (out_valid_q && out_stall) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (!out_valid_q || !out_stall) begin
				out_ang_q <= skid_ang_q;
			end
		end else if (arrive) begin
			if (out_valid_q && out_stall) begin
				skid_ang_q <= res;
			end else begin
				out_ang_q <= res;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign turn_angle = out_ang_q;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a request while the output register is empty");

	a_skid_fill_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_valid_q) |-> $past(out_valid_q && out_stall && in_vld))
		else $error("skid filled without a stalled output");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_ang_q <= sta_pkg::ANG_PI && out_ang_q >= -sta_pkg::ANG_PI))
		else $error("turn angle outside +-pi");
`endif

endmodule

FILE: hw/rtl/signed_turn_angle.sv
// signed turn angle at the middle point B of a path A-B-C: coordinates are
// Q12.4 two's complement, the block forms AB and BC, their exact dot and
// cross products, and returns atan2(cross, dot) in radians times 8192
// (range -25736..25736, positive is counter-clockwise) from a vectoring
// cordic with a quadrant pre-rotation; a zero cross gives 0, or +pi when
// the dot is negative. one request is taken every clock cycle while in_stall
// is low; the result passes through 4 front stages for differences, products,
// sums and pre-rotation, 16 cordic stages and one output register. a two-entry
// output register with skid keeps the in_stall path registered: the
// pipeline freezes only while the skid entry is occupied.
module signed_turn_angle (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [sta_pkg::COORD_BITS-1:0] a_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] a_x,
	input  logic signed [sta_pkg::COORD_BITS-1:0] b_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] b_x,
	input  logic signed [sta_pkg::COORD_BITS-1:0] c_y,
	input  logic signed [sta_pkg::COORD_BITS-1:0] c_x,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [sta_pkg::ANG_W-1:0]      turn_angle
);

	// pipeline advance, low only while the skid entry holds a request
	logic          en;

	// valid bits and vectors between stages, index 0 is the front output
	logic          vld_chain [0:sta_pkg::CORDIC_STEPS];
	sta_pkg::rot_t rot_chain [0:sta_pkg::CORDIC_STEPS];

	assign in_stall = !en;

	// differences, products, dot/cross and quadrant pre-rotation
	sta_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (in_valid),
		.a_y     (a_y),
		.a_x     (a_x),
		.b_y     (b_y),
		.b_x     (b_x),
		.c_y     (c_y),
		.c_x     (c_x),
		.out_vld (vld_chain[0]),
		.out_rot (rot_chain[0])
	);

	// one registered micro-rotation per cordic step
	for (genvar s = 0; s < sta_pkg::CORDIC_STEPS; s++) begin : g_step
		sta_cordic_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.step    (sta_pkg::STEP_W'(s)),
			.in_vld  (vld_chain[s]),
			.in_rot  (rot_chain[s]),
			.out_vld (vld_chain[s+1]),
			.out_rot (rot_chain[s+1])
		);
	end

	// special cases, clamp, output register and skid
	sta_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (vld_chain[sta_pkg::CORDIC_STEPS]),
		.in_rot     (rot_chain[sta_pkg::CORDIC_STEPS]),
		.en         (en),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.turn_angle (turn_angle)
	);

endmodule
